FILE: rtl/cau_pkg.sv
// Shared types and defaults for the complex arithmetic unit.
// No dependencies; imported by cau_div and complex_arithmetic_unit.
package cau_pkg;

    localparam int CAU_DATA_WIDTH = 16;
    localparam int CAU_FRAC_BITS  = 8;
    localparam int CAU_STATUS_W   = 2;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    typedef enum logic [CAU_STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_DIV0 = 2'd1,
        ST_SAT  = 2'd2
    } t_status;

endpackage

FILE: rtl/cau_div.sv
// Pipelined restoring divider for two numerators over one shared divisor.
// Depends on cau_pkg; one quotient bit per stage, side payload travels along.
module cau_div
    import cau_pkg::*;
#(
    parameter int DATA_WIDTH = CAU_DATA_WIDTH,
    parameter int FRAC_BITS  = CAU_FRAC_BITS,
    parameter int SIDE_W     = 1,
    localparam int QB = DATA_WIDTH + 1,
    localparam int DW = 2 * DATA_WIDTH,
    localparam int XW = 3 * DATA_WIDTH + FRAC_BITS + 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [XW-1:0]     i_num_re,
    input  logic [XW-1:0]     i_num_im,
    input  logic [DW-1:0]     i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [QB-1:0]     o_q_re,
    output logic [QB-1:0]     o_q_im,
    output logic [SIDE_W-1:0] o_side
);

    logic              r_valid [QB];
    logic [XW-1:0]     r_rem_re [QB];
    logic [XW-1:0]     r_rem_im [QB];
    logic [QB-1:0]     r_q_re [QB];
    logic [QB-1:0]     r_q_im [QB];
    logic [DW-1:0]     r_den [QB];
    logic [SIDE_W-1:0] r_side [QB];

    for (genvar k = 0; k < QB; k++) begin : g_stage
        logic              v_in;
        logic [XW-1:0]     rem_re_in, rem_im_in, dsh;
        logic [QB-1:0]     q_re_in, q_im_in;
        logic [DW-1:0]     den_in;
        logic [SIDE_W-1:0] side_in;
        logic              ge_re, ge_im;
        logic [XW-1:0]     n_rem_re, n_rem_im;
        logic [QB-1:0]     n_q_re, n_q_im;

        if (k == 0) begin : g_first
            assign v_in      = i_valid;
            assign rem_re_in = i_num_re;
            assign rem_im_in = i_num_im;
            assign q_re_in   = '0;
            assign q_im_in   = '0;
            assign den_in    = i_den;
            assign side_in   = i_side;
        end else begin : g_next
            assign v_in      = r_valid[k-1];
            assign rem_re_in = r_rem_re[k-1];
            assign rem_im_in = r_rem_im[k-1];
            assign q_re_in   = r_q_re[k-1];
            assign q_im_in   = r_q_im[k-1];
            assign den_in    = r_den[k-1];
            assign side_in   = r_side[k-1];
        end

        // trial subtract of the divisor aligned to this quotient bit
        assign dsh      = XW'(den_in) << (QB - 1 - k);
        assign ge_re    = rem_re_in >= dsh;
        assign ge_im    = rem_im_in >= dsh;
        assign n_rem_re = ge_re ? rem_re_in - dsh : rem_re_in;
        assign n_rem_im = ge_im ? rem_im_in - dsh : rem_im_in;
        assign n_q_re   = q_re_in | (QB'(ge_re) << (QB - 1 - k));
        assign n_q_im   = q_im_in | (QB'(ge_im) << (QB - 1 - k));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_en) begin
                r_valid[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem_re[k] <= n_rem_re;
                r_rem_im[k] <= n_rem_im;
                r_q_re[k]   <= n_q_re;
                r_q_im[k]   <= n_q_im;
                r_den[k]    <= den_in;
                r_side[k]   <= side_in;
            end
        end
    end

    assign o_valid = r_valid[QB-1];
    assign o_q_re  = r_q_re[QB-1];
    assign o_q_im  = r_q_im[QB-1];
    assign o_side  = r_side[QB-1];

endmodule

FILE: rtl/complex_arithmetic_unit.sv
// Complex add / subtract / multiply / divide on signed fixed-point operands.
// Depends on cau_pkg and cau_div.
//
// Usage: an item (operation code plus operands A and B, each real and
// imaginary part DATA_WIDTH bits with FRAC_BITS fraction bits) is taken on
// the input channel when i_valid is high and o_stall is low. One result
// item (res_re, res_im, status) leaves per input item, in order, when
// o_valid is high and i_stall is low.
// Each item passes three stages for products, sums and scaling, one
// stage per quotient bit in the divider (DATA_WIDTH + 1 of them), and
// the output register. Throughput is one item per cycle while the
// receiver does not stall; every operation walks the same pipeline so
// results never reorder.
// Reset (synchronous, active low) drops every item in flight.
// While the receiver stalls a waiting result, the whole pipeline holds and
// o_stall rises; an empty output register lets the pipeline advance.
// Status: 0 ok, 1 divide by zero (result zero), 2 a part saturated.
module complex_arithmetic_unit
    import cau_pkg::*;
#(
    parameter int DATA_WIDTH = CAU_DATA_WIDTH,
    parameter int FRAC_BITS  = CAU_FRAC_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [1:0]                   i_req_type,
    input  logic signed [DATA_WIDTH-1:0] i_a_re,
    input  logic signed [DATA_WIDTH-1:0] i_a_im,
    input  logic signed [DATA_WIDTH-1:0] i_b_re,
    input  logic signed [DATA_WIDTH-1:0] i_b_im,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [DATA_WIDTH-1:0] o_res_re,
    output logic signed [DATA_WIDTH-1:0] o_res_im,
    output logic [CAU_STATUS_W-1:0]      o_status
);

    localparam int W      = DATA_WIDTH;
    localparam int PW     = 2 * W;       // product width
    localparam int SW     = 2 * W + 1;   // sum of two products
    localparam int QB     = W + 1;       // quotient bits kept
    localparam int XW     = 3 * W + FRAC_BITS + 2;
    localparam int SIDE_W = 2 * W + 7;

    localparam logic signed [SW-1:0] MAXV = (SW'(1) <<< (W - 1)) - SW'(1);
    localparam logic signed [SW-1:0] MINV = -MAXV - SW'(1);
    localparam logic [QB-1:0]        HALF = QB'(1) << (W - 1);
    localparam logic signed [W-1:0]  RMAX = W'(MAXV);
    localparam logic signed [W-1:0]  RMIN = W'(MINV);

    logic en;

    // Advance everything unless a finished result waits on a stalled receiver
    assign en      = !o_valid || !i_stall;
    assign o_stall = !en;

    // ---------------- stage 1: products and add/subtract ----------------
    logic                 r1_valid;
    t_op                  r1_op;
    logic signed [PW-1:0] r1_p_rr, r1_p_ii, r1_p_ri, r1_p_ir, r1_bb_r, r1_bb_i;
    logic signed [W:0]    r1_as_re, r1_as_im;
    logic signed [W:0]    n1_as_re, n1_as_im;

    always_comb begin
        if (t_op'(i_req_type) == OP_SUB) begin
            n1_as_re = (W+1)'(i_a_re) - (W+1)'(i_b_re);
            n1_as_im = (W+1)'(i_a_im) - (W+1)'(i_b_im);
        end else begin
            n1_as_re = (W+1)'(i_a_re) + (W+1)'(i_b_re);
            n1_as_im = (W+1)'(i_a_im) + (W+1)'(i_b_im);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (en) begin
            r1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_op    <= t_op'(i_req_type);
            r1_p_rr  <= i_a_re * i_b_re;
            r1_p_ii  <= i_a_im * i_b_im;
            r1_p_ri  <= i_a_re * i_b_im;
            r1_p_ir  <= i_a_im * i_b_re;
            r1_bb_r  <= i_b_re * i_b_re;
            r1_bb_i  <= i_b_im * i_b_im;
            r1_as_re <= n1_as_re;
            r1_as_im <= n1_as_im;
        end
    end

    // ---------------- stage 2: product sums ----------------
    logic                 r2_valid;
    t_op                  r2_op;
    logic signed [SW-1:0] r2_mul_re, r2_mul_im, r2_num_re, r2_num_im, r2_as_re, r2_as_im;
    logic [PW-1:0]        r2_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (en) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_op     <= r1_op;
            r2_mul_re <= SW'(r1_p_rr) - SW'(r1_p_ii);
            r2_mul_im <= SW'(r1_p_ri) + SW'(r1_p_ir);
            // A * conj(B)
            r2_num_re <= SW'(r1_p_rr) + SW'(r1_p_ii);
            r2_num_im <= SW'(r1_p_ir) - SW'(r1_p_ri);
            r2_den    <= PW'(r1_bb_r) + PW'(r1_bb_i);
            r2_as_re  <= SW'(r1_as_re);
            r2_as_im  <= SW'(r1_as_im);
        end
    end

    // ---------------- stage 3: scale, clamp, divider set-up ----------------
    logic signed [SW-1:0] v3_re, v3_im;
    logic [SW-1:0]        m3_re, m3_im;
    logic [XW-1:0]        x3_re, x3_im, d3_lim;
    logic                 neg3_re, neg3_im, zero3, sat3;
    logic [W-1:0]         c3_re, c3_im;

    always_comb begin
        if (r2_op == OP_MUL) begin
            v3_re = r2_mul_re >>> FRAC_BITS;    // floor
            v3_im = r2_mul_im >>> FRAC_BITS;
        end else begin
            v3_re = r2_as_re;
            v3_im = r2_as_im;
        end
        sat3  = (v3_re > MAXV) || (v3_re < MINV) || (v3_im > MAXV) || (v3_im < MINV);
        c3_re = (v3_re > MAXV) ? W'(MAXV) : (v3_re < MINV) ? W'(MINV) : W'(v3_re);
        c3_im = (v3_im > MAXV) ? W'(MAXV) : (v3_im < MINV) ? W'(MINV) : W'(v3_im);

        neg3_re = r2_num_re[SW-1];
        neg3_im = r2_num_im[SW-1];
        m3_re   = neg3_re ? SW'(-r2_num_re) : SW'(r2_num_re);
        m3_im   = neg3_im ? SW'(-r2_num_im) : SW'(r2_num_im);
        x3_re   = XW'(m3_re) << FRAC_BITS;
        x3_im   = XW'(m3_im) << FRAC_BITS;
        d3_lim  = XW'(r2_den) << QB;
        zero3   = (r2_den == '0);
    end

    logic                r3_valid;
    logic [XW-1:0]       r3_num_re, r3_num_im;
    logic [PW-1:0]       r3_den;
    logic [SIDE_W-1:0]   r3_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (en) begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_num_re <= x3_re;
            r3_num_im <= x3_im;
            r3_den    <= r2_den;
            // quotient at or beyond 2^QB saturates whatever its sign
            r3_side   <= {r2_op == OP_DIV, zero3, x3_re >= d3_lim, x3_im >= d3_lim,
                          neg3_re, neg3_im, sat3, c3_re, c3_im};
        end
    end

    // ---------------- divider ----------------
    logic              dv_valid;
    logic [QB-1:0]     dv_q_re, dv_q_im;
    logic [SIDE_W-1:0] dv_side;

    cau_div #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS),
        .SIDE_W     (SIDE_W)
    ) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (r3_valid),
        .i_num_re (r3_num_re),
        .i_num_im (r3_num_im),
        .i_den    (r3_den),
        .i_side   (r3_side),
        .o_valid  (dv_valid),
        .o_q_re   (dv_q_re),
        .o_q_im   (dv_q_im),
        .o_side   (dv_side)
    );

    // ---------------- final stage: sign, clamp, status ----------------
    logic         f_div, f_zero, f_ovf_re, f_ovf_im, f_neg_re, f_neg_im, f_sat;
    logic [W-1:0] f_c_re, f_c_im;
    logic [W-1:0] n_res_re, n_res_im;
    logic         sat_re, sat_im;
    t_status      n_status;

    assign {f_div, f_zero, f_ovf_re, f_ovf_im, f_neg_re, f_neg_im, f_sat, f_c_re, f_c_im}
        = dv_side;

    always_comb begin
        sat_re = f_ovf_re || (f_neg_re ? (dv_q_re > HALF) : (dv_q_re > HALF - QB'(1)));
        sat_im = f_ovf_im || (f_neg_im ? (dv_q_im > HALF) : (dv_q_im > HALF - QB'(1)));
        if (!f_div) begin
            n_res_re = f_c_re;
            n_res_im = f_c_im;
            n_status = f_sat ? ST_SAT : ST_OK;
        end else if (f_zero) begin
            n_res_re = '0;
            n_res_im = '0;
            n_status = ST_DIV0;
        end else begin
            n_res_re = sat_re ? (f_neg_re ? RMIN : RMAX)
                              : (f_neg_re ? W'(-dv_q_re) : W'(dv_q_re));
            n_res_im = sat_im ? (f_neg_im ? RMIN : RMAX)
                              : (f_neg_im ? W'(-dv_q_im) : W'(dv_q_im));
            n_status = (sat_re || sat_im) ? ST_SAT : ST_OK;
        end
    end

    logic    r_out_valid;
    t_status r_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= dv_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_res_re <= n_res_re;
            o_res_im <= n_res_im;
            r_status <= n_status;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_status = r_status;

    // ---------------- assertions ----------------
    a_div0_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_DIV0) |-> (o_res_re == '0) && (o_res_im == '0))
        else $error("divide by zero with non-zero result");

    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_SAT) |->
            (o_res_re == RMAX) || (o_res_re == RMIN) ||
            (o_res_im == RMAX) || (o_res_im == RMIN))
        else $error("saturation flagged without a limit value");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == ST_OK) || (o_status == ST_DIV0) || (o_status == ST_SAT))
        else $error("undefined status code");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !r1_valid && !r3_valid)
        else $error("items survive reset");

endmodule

FILE: tb/sv/complex_arithmetic_unit_test.sv
// Self-checking bench for complex_arithmetic_unit: directed table, then random items.
// Depends on cau_pkg and the complex_arithmetic_unit RTL.
`timescale 1ns / 1ps

module complex_arithmetic_unit_test;
    import cau_pkg::*;

    localparam int DW = CAU_DATA_WIDTH;
    localparam int FB = CAU_FRAC_BITS;
    localparam int LATENCY = DW + 5;
    localparam logic signed [DW-1:0] MAXV = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] MINV = {1'b1, {(DW-1){1'b0}}};

    typedef struct packed {
        logic signed [DW-1:0] re;
        logic signed [DW-1:0] im;
        t_status              st;
    } t_cplx_res;

    typedef struct {
        t_op                  op;
        logic signed [DW-1:0] ar, ai, br, bi;
        bit                   typed;    // expected result written in the row
        t_cplx_res            res;
    } t_row;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [1:0]            req_type = 2'd0;
    logic signed [DW-1:0]  a_re = '0, a_im = '0, b_re = '0, b_im = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic signed [DW-1:0]  res_re, res_im;
    logic [CAU_STATUS_W-1:0] res_status;

    t_cplx_res pending_results[$];
    int        mismatches = 0;
    int        results_seen = 0;
    int        ops_sent[4] = '{0, 0, 0, 0};
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;

    complex_arithmetic_unit dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_valid    (in_valid),
        .o_stall    (in_stall),
        .i_req_type (req_type),
        .i_a_re     (a_re),
        .i_a_im     (a_im),
        .i_b_re     (b_re),
        .i_b_im     (b_im),
        .o_valid    (out_valid),
        .i_stall    (out_stall),
        .o_res_re   (res_re),
        .o_res_im   (res_im),
        .o_status   (res_status)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Clamp a wide signed value to the output width, flagging saturation.
    function automatic logic signed [DW-1:0] clamp_part(input longint v, inout bit sat);
        if (v > longint'(MAXV)) begin
            sat = 1'b1;
            return MAXV;
        end
        if (v < longint'(MINV)) begin
            sat = 1'b1;
            return MINV;
        end
        return v[DW-1:0];
    endfunction

    // Compute the expected result of one item; all sums fit in 64 bits at this width.
    function automatic t_cplx_res complex_result(input t_op op,
            input logic signed [DW-1:0] ar, ai, br, bi);
        t_cplx_res r;
        bit        sat;
        longint    xr, xi, d;
        longint    nr, ni;
        sat = 1'b0;
        r.st = ST_OK;
        r.re = '0;
        r.im = '0;
        case (op)
            OP_ADD, OP_SUB: begin
                xr = (op == OP_ADD) ? longint'(ar) + longint'(br) : longint'(ar) - longint'(br);
                xi = (op == OP_ADD) ? longint'(ai) + longint'(bi) : longint'(ai) - longint'(bi);
                r.re = clamp_part(xr, sat);
                r.im = clamp_part(xi, sat);
            end
            OP_MUL: begin
                xr = longint'(ar) * br - longint'(ai) * bi;
                xi = longint'(ar) * bi + longint'(ai) * br;
                // arithmetic shift floors toward minus infinity
                r.re = clamp_part(xr >>> FB, sat);
                r.im = clamp_part(xi >>> FB, sat);
            end
            default: begin
                d = longint'(br) * br + longint'(bi) * bi;
                if (d == 0) begin
                    r.st = ST_DIV0;
                end else begin
                    nr = (longint'(ar) * br + longint'(ai) * bi) * (longint'(1) << FB);
                    ni = (longint'(ai) * br - longint'(ar) * bi) * (longint'(1) << FB);
                    // SystemVerilog division truncates toward zero
                    r.re = clamp_part(nr / d, sat);
                    r.im = clamp_part(ni / d, sat);
                end
            end
        endcase
        if (sat)
            r.st = ST_SAT;
        return r;
    endfunction

    // Directed rows: extremes, every operation, floor, truncation, saturation, zero divisor.
    t_row directed[] = '{
        '{OP_ADD, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1, '{16'sd0, 16'sd0, ST_OK}},
        '{OP_ADD, MAXV, MAXV, 16'sd1, 16'sd0, 1, '{MAXV, MAXV, ST_SAT}},
        '{OP_ADD, MINV, MINV, -16'sd1, MINV, 1, '{MINV, MINV, ST_SAT}},
        '{OP_ADD, MAXV, MINV, MINV, MAXV, 1, '{-16'sd1, -16'sd1, ST_OK}},
        '{OP_SUB, MINV, MAXV, 16'sd1, -16'sd1, 1, '{MINV, MAXV, ST_SAT}},
        '{OP_SUB, MAXV, MAXV, MAXV, MAXV, 1, '{16'sd0, 16'sd0, ST_OK}},
        '{OP_SUB, 16'sd0, 16'sd0, MINV, MINV, 1, '{MAXV, MAXV, ST_SAT}},
        '{OP_MUL, 16'sd256, 16'sd0, 16'sd256, 16'sd0, 1, '{16'sd256, 16'sd0, ST_OK}},
        '{OP_MUL, 16'sd0, 16'sd256, 16'sd0, 16'sd256, 1, '{-16'sd256, 16'sd0, ST_OK}},
        '{OP_MUL, -16'sd1, 16'sd0, 16'sd1, 16'sd0, 0, '{16'sd0, 16'sd0, ST_OK}},
        '{OP_MUL, 16'sd1, 16'sd1, 16'sd1, 16'sd1, 0, '{16'sd0, 16'sd0, ST_OK}},
        '{OP_MUL, MINV, MINV, MINV, MINV, 1, '{16'sd0, MAXV, ST_SAT}},
        '{OP_MUL, MAXV, MINV, MAXV, MAXV, 0, '{16'sd0, 16'sd0, ST_OK}},
        '{OP_MUL, MINV, 16'sd0, MINV, 16'sd0, 1, '{MAXV, 16'sd0, ST_SAT}},
        '{OP_DIV, 16'sd256, 16'sd256, 16'sd0, 16'sd0, 1, '{16'sd0, 16'sd0, ST_DIV0}},
        '{OP_DIV, MAXV, MINV, 16'sd0, 16'sd0, 1, '{16'sd0, 16'sd0, ST_DIV0}},
        '{OP_DIV, 16'sd256, 16'sd0, 16'sd256, 16'sd0, 1, '{16'sd256, 16'sd0, ST_OK}},
        '{OP_DIV, 16'sd256, 16'sd0, 16'sd768, 16'sd0, 0, '{16'sd0, 16'sd0, ST_OK}},
        '{OP_DIV, -16'sd256, 16'sd0, 16'sd768, 16'sd0, 0, '{16'sd0, 16'sd0, ST_OK}},
        '{OP_DIV, MAXV, MAXV, 16'sd1, 16'sd0, 1, '{MAXV, MAXV, ST_SAT}},
        '{OP_DIV, MINV, MINV, 16'sd0, 16'sd1, 1, '{MINV, MAXV, ST_SAT}},
        '{OP_DIV, MINV, MINV, MINV, MINV, 0, '{16'sd0, 16'sd0, ST_OK}},
        '{OP_DIV, 16'sd3, -16'sd5, MAXV, MINV, 0, '{16'sd0, 16'sd0, ST_OK}},
        '{OP_DIV, MAXV, 16'sd0, 16'sd0, -16'sd1, 0, '{16'sd0, 16'sd0, ST_OK}}
    };

    // Pick a field value: mostly random, sometimes an extreme or small.
    function automatic logic signed [DW-1:0] pick_field();
        case ($urandom_range(9))
            0: return MAXV;
            1: return MINV;
            2: return 16'(int'($urandom_range(8)) - 4);
            3: return 16'(int'($urandom_range(2048)) - 1024);
            default: return DW'($urandom());
        endcase
    endfunction

    // Present one item and hold it until accepted.
    task automatic send_item(input t_op op, input logic signed [DW-1:0] ar, ai, br, bi,
            input bit typed, input t_cplx_res typed_res);
        t_cplx_res predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        predicted = complex_result(op, ar, ai, br, bi);
        pending_results.push_back(typed ? typed_res : predicted);
        ops_sent[op]++;
        in_valid <= 1'b1;
        req_type <= op;
        a_re <= ar;
        a_im <= ai;
        b_re <= br;
        b_im <= bi;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Receiver: drive stall, check each accepted result against the oldest expectation.
    always @(posedge clk) begin
        t_cplx_res want;
        if (rst_n && out_valid && !out_stall) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result re=%0d im=%0d st=%0d",
                             res_re, res_im, res_status);
            end else begin
                want = pending_results.pop_front();
                if (res_re !== want.re || res_im !== want.im || res_status !== want.st) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"result mismatch: expected re=%0d im=%0d st=%0d,",
                                  " got re=%0d im=%0d st=%0d"},
                                 want.re, want.im, want.st, res_re, res_im, res_status);
                end
            end
        end
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    initial begin
        #2000000;
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        t_op op;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table; unchecked rows fall back on the predictor.
        foreach (directed[i])
            send_item(directed[i].op, directed[i].ar, directed[i].ai, directed[i].br,
                      directed[i].bi, directed[i].typed, directed[i].res);
        // Hold off until the pipeline has emptied at least once.
        wait_drained();

        // Three phases: receiver-heavy idling, sender-heavy idling, none.
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 25 : (phase == 1) ? 60 : 0;
            recv_idle_pct = (phase == 0) ? 60 : (phase == 1) ? 25 : 0;
            for (int n = 0; n < 475; n++) begin
                op = t_op'($urandom_range(3));
                // Occasionally force a zero divisor.
                if (op == OP_DIV && $urandom_range(15) == 0)
                    send_item(op, pick_field(), pick_field(), '0, '0, 0, '0);
                else
                    send_item(op, pick_field(), pick_field(), pick_field(), pick_field(),
                              0, '0);
            end
            wait_drained();
        end

        recv_idle_pct = 0;
        repeat (LATENCY + 5) @(posedge clk);
        $display("covered %0d add, %0d sub, %0d mul, %0d div items; %0d results checked",
                 ops_sent[0], ops_sent[1], ops_sent[2], ops_sent[3], results_seen);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

FILE: sim.f
rtl/cau_pkg.sv
rtl/cau_div.sv
rtl/complex_arithmetic_unit.sv
tb/sv/complex_arithmetic_unit_test.sv
